FILE: rtl/core/bbr_pkg.sv
// Shared types, constants and helper functions of the 3x3 RGB box blur.
// No dependencies; every other file of the block but bbr_ram imports this package.
package bbr_pkg;

    localparam int PIX_W             = 8;
    localparam int CFG_DATA_W        = 11;
    localparam int CFG_INDEX_W       = 1;
    localparam int HEIGHT_W          = 11;
    localparam int OUT_ROW_W         = 10;
    localparam int HEIGHT_LIMIT      = 1024;
    localparam int FRAME_DIM_RESET   = 500;
    localparam int MAX_WIDTH_DEFAULT = 1024;
    localparam int OUT_DEPTH_DEFAULT = 8;
    localparam int WIN_COLS          = 3;
    localparam int COL_SUM_W         = 10;
    localparam int WIN_SUM_W         = 12;

    // floor(s / 9) == (s * 3641) >> 15 for every s below 2^15
    localparam int DIV9_MULT   = 3641;
    localparam int DIV9_SHIFT  = 15;
    localparam int DIV9_PROD_W = 24;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } pixel_t;

    // One window column: top is two rows above the incoming pixel, bot is the pixel itself
    typedef struct packed {
        pixel_t top;
        pixel_t mid;
        pixel_t bot;
    } column_t;

    typedef struct packed {
        logic top_off;
        logic bot_off;
    } row_mask_t;

    typedef struct packed {
        logic [COL_SUM_W-1:0] red;
        logic [COL_SUM_W-1:0] green;
        logic [COL_SUM_W-1:0] blue;
    } col_sum_t;

    typedef struct packed {
        logic [WIN_SUM_W-1:0] red;
        logic [WIN_SUM_W-1:0] green;
        logic [WIN_SUM_W-1:0] blue;
    } win_sum_t;

    typedef struct packed {
        logic primed;
        logic col_first;
        logic col_last;
        logic row_first;
        logic row_last;
    } pos_t;

    typedef struct packed {
        pixel_t px;
        logic   row_end;
        logic   frame_end;
    } result_t;

    function automatic logic [HEIGHT_W-1:0] clamp_height(input logic [CFG_DATA_W-1:0] value);
        logic [HEIGHT_W-1:0] res;
        if (value == '0) begin
            res = HEIGHT_W'(1);
        end
        else if (value > CFG_DATA_W'(HEIGHT_LIMIT)) begin
            res = HEIGHT_W'(HEIGHT_LIMIT);
        end
        else begin
            res = HEIGHT_W'(value);
        end
        return res;
    endfunction

    function automatic logic [PIX_W-1:0] div9(input logic [WIN_SUM_W-1:0] sum);
        logic [DIV9_PROD_W-1:0] prod;
        prod = DIV9_PROD_W'(sum) * DIV9_PROD_W'(DIV9_MULT);
        return prod[DIV9_SHIFT +: PIX_W];
    endfunction

endpackage

FILE: rtl/core/bbr_if.sv
// Valid/ready stream interfaces for source pixels and blurred pixels.
// Depends on bbr_pkg for the channel width.
interface bbr_in_if;
    import bbr_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] in_red;
    logic [PIX_W-1:0] in_green;
    logic [PIX_W-1:0] in_blue;
    logic             drain;

    modport source (output valid, output in_red, output in_green, output in_blue,
                    output drain, input ready);
    modport sink   (input valid, input in_red, input in_green, input in_blue,
                    input drain, output ready);
endinterface

interface bbr_out_if;
    import bbr_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] out_red;
    logic [PIX_W-1:0] out_green;
    logic [PIX_W-1:0] out_blue;
    logic             row_end;
    logic             frame_end;

    modport source (output valid, output out_red, output out_green, output out_blue,
                    output row_end, output frame_end, input ready);
    modport sink   (input valid, input out_red, input out_green, input out_blue,
                    input row_end, input frame_end, output ready);
endinterface

FILE: rtl/core/box_blur_3x3_rgb.sv
// Streaming 3x3 box blur over RGB pixels in raster order. The block takes one pixel
// request per clock while input ready is high; the sustained rate is one pixel per clock,
// set by the single write and read port of each line store and the one-column shift of
// the window cells. Neighbours outside the frame count as zero and the sum is always
// divided by 9, so borders darken. The output lags the input by one row plus one pixel:
// after the width*height pixels of a frame, send width+1 requests with drain set. Input
// ready drops only when OUT_DEPTH results are outstanding. Writing either register
// restarts the frame. Depends on bbr_pkg, bbr_if, bbr_ram, bbr_cell and bbr_out_fifo.
module box_blur_3x3_rgb import bbr_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT,
    parameter int OUT_DEPTH = OUT_DEPTH_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    bbr_in_if.sink                 pixels,
    bbr_out_if.source              blurred
);

    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int CW  = $clog2(MAX_WIDTH + 1);
    localparam int CRW = $clog2(OUT_DEPTH + 1);
    localparam logic [CW-1:0] WIDTH_RESET =
        CW'((FRAME_DIM_RESET > MAX_WIDTH) ? MAX_WIDTH : FRAME_DIM_RESET);
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(FRAME_DIM_RESET);

    function automatic logic [CW-1:0] clamp_width(input logic [CFG_DATA_W-1:0] value);
        logic [CW-1:0] res;
        if (value == '0)
        begin
            res = CW'(1);
        end
        else if (int'(value) > MAX_WIDTH)
        begin
            res = CW'(MAX_WIDTH);
        end
        else
        begin
            res = CW'(value);
        end
        return res;
    endfunction

    // Frame geometry and position counters
    logic [CW-1:0]        width_reg;
    logic [HEIGHT_W-1:0]  height_reg;
    logic [CW-1:0]        in_col_reg, in_col_next;
    logic [HEIGHT_W-1:0]  in_row_reg, in_row_next;
    logic [CW-1:0]        out_col_reg, out_col_next;
    logic [OUT_ROW_W-1:0] out_row_reg, out_row_next;

    logic    accept;
    logic    pop;
    logic    primed;
    logic    in_wrap;
    logic    out_col_last;
    logic    out_row_last;
    pixel_t  in_pix;
    pos_t    acc_pos;
    logic [AW-1:0] rd_addr;

    // Stage 1: line store data returns
    logic          s1_valid_reg;
    logic [AW-1:0] s1_addr_reg;
    pixel_t        s1_pix_reg;
    pos_t          s1_pos_reg;
    logic          fwd_reg;
    pixel_t        fwd_older_reg;
    pixel_t        fwd_newer_reg;
    pixel_t        older_rd;
    pixel_t        newer_rd;
    pixel_t        older_eff;
    pixel_t        newer_eff;
    column_t       new_col;

    // Stage 2: window holds the item's columns
    logic      s2_valid_reg;
    pos_t      s2_pos_reg;
    logic      win_clear;
    row_mask_t row_mask;
    column_t   cell_in  [WIN_COLS];
    column_t   cell_col [WIN_COLS];
    col_sum_t  cell_sum [WIN_COLS];
    col_sum_t  left_sum;
    col_sum_t  right_sum;
    win_sum_t  win_sum;

    // Stage 3: window sums, divided on the way into the output FIFO
    logic     s3_valid_reg;
    win_sum_t s3_sum_reg;
    logic     s3_row_end_reg;
    logic     s3_frame_end_reg;
    result_t  push_data;
    result_t  head;
    logic     fifo_valid;

    logic [CRW-1:0] credit_reg, credit_next;

    assign accept = pixels.valid && pixels.ready;
    assign pop    = blurred.valid && blurred.ready;

    assign pixels.ready = (credit_reg < CRW'(OUT_DEPTH));

    // Count results that are owed to the FIFO or sit in it
    always_comb
    begin
        credit_next = credit_reg + CRW'(accept && primed) - CRW'(pop);
    end

    assign in_wrap      = (({1'b0, in_col_reg} + 1'b1) >= {1'b0, width_reg});
    assign out_col_last = (({1'b0, out_col_reg} + 1'b1) >= {1'b0, width_reg});
    assign out_row_last = (({1'b0, out_row_reg} + 1'b1) >= height_reg);
    assign primed       = (in_row_reg >= HEIGHT_W'(2))
                       || ((in_row_reg == HEIGHT_W'(1)) && (in_col_reg != '0));

    assign in_pix = (!pixels.drain && (in_row_reg < height_reg))
                  ? pixel_t'{red: pixels.in_red, green: pixels.in_green, blue: pixels.in_blue}
                  : '0;

    assign acc_pos = '{primed:    primed,
                       col_first: (out_col_reg == '0),
                       col_last:  out_col_last,
                       row_first: (out_row_reg == '0),
                       row_last:  out_row_last};

    assign rd_addr = in_col_reg[AW-1:0];

    always_comb
    begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (accept)
        begin
            if (primed && out_col_last && out_row_last)
            begin
                in_col_next  = '0;
                in_row_next  = '0;
                out_col_next = '0;
                out_row_next = '0;
            end
            else
            begin
                if (in_wrap)
                begin
                    in_col_next = '0;
                    in_row_next = in_row_reg + 1'b1;
                end
                else
                begin
                    in_col_next = in_col_reg + 1'b1;
                end
                if (primed)
                begin
                    if (out_col_last)
                    begin
                        out_col_next = '0;
                        out_row_next = out_row_reg + 1'b1;
                    end
                    else
                    begin
                        out_col_next = out_col_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= WIDTH_RESET;
            height_reg  <= HEIGHT_RESET;
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            credit_reg  <= '0;
        end
        else
        begin
            credit_reg <= credit_next;
            if (cfg_wr_en)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_FRAME_WIDTH:  width_reg  <= clamp_width(cfg_data);
                    REG_FRAME_HEIGHT: height_reg <= clamp_height(cfg_data);
                    default:          width_reg  <= width_reg;
                endcase
                // restart the frame
                in_col_reg  <= '0;
                in_row_reg  <= '0;
                out_col_reg <= '0;
                out_row_reg <= '0;
            end
            else
            begin
                in_col_reg  <= in_col_next;
                in_row_reg  <= in_row_next;
                out_col_reg <= out_col_next;
                out_row_reg <= out_row_next;
            end
        end
    end

    // Line stores: older holds the row two above, newer the row just above
    bbr_ram #(
        .WIDTH ($bits(pixel_t)),
        .DEPTH (MAX_WIDTH)
    ) u_older_line (
        .clk     (clk),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_addr_reg),
        .wr_data (newer_eff),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (older_rd)
    );

    bbr_ram #(
        .WIDTH ($bits(pixel_t)),
        .DEPTH (MAX_WIDTH)
    ) u_newer_line (
        .clk     (clk),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_addr_reg),
        .wr_data (s1_pix_reg),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (newer_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            if (accept)
            begin
                // a write to the same column at this edge is missed by the read: forward it
                fwd_reg <= s1_valid_reg && (s1_addr_reg == rd_addr);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_addr_reg   <= rd_addr;
            s1_pix_reg    <= in_pix;
            s1_pos_reg    <= acc_pos;
            fwd_older_reg <= newer_eff;
            fwd_newer_reg <= s1_pix_reg;
        end
    end

    assign older_eff = fwd_reg ? fwd_older_reg : older_rd;
    assign newer_eff = fwd_reg ? fwd_newer_reg : newer_rd;
    assign new_col   = '{top: older_eff, mid: newer_eff, bot: s1_pix_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            s2_pos_reg <= s1_pos_reg;
        end
    end

    // Empty the window after the last pixel of a frame or on a register write
    assign win_clear = cfg_wr_en
                    || (s2_valid_reg && s2_pos_reg.primed && s2_pos_reg.col_last
                        && s2_pos_reg.row_last);
    assign row_mask  = '{top_off: s2_pos_reg.row_first, bot_off: s2_pos_reg.row_last};

    // Cell 0 holds the oldest column, the last cell takes the new one
    for (genvar j = 0; j < WIN_COLS; j++)
    begin : g_cell
        if (j == WIN_COLS - 1)
        begin : g_head
            assign cell_in[j] = new_col;
        end
        else
        begin : g_body
            assign cell_in[j] = win_clear ? '0 : cell_col[j + 1];
        end

        bbr_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .shift   (s1_valid_reg),
            .clear   (win_clear),
            .col_in  (cell_in[j]),
            .mask    (row_mask),
            .col_out (cell_col[j]),
            .sum     (cell_sum[j])
        );
    end

    assign left_sum  = s2_pos_reg.col_first ? '0 : cell_sum[0];
    assign right_sum = s2_pos_reg.col_last  ? '0 : cell_sum[WIN_COLS - 1];

    assign win_sum.red   = WIN_SUM_W'(left_sum.red) + WIN_SUM_W'(cell_sum[1].red)
                         + WIN_SUM_W'(right_sum.red);
    assign win_sum.green = WIN_SUM_W'(left_sum.green) + WIN_SUM_W'(cell_sum[1].green)
                         + WIN_SUM_W'(right_sum.green);
    assign win_sum.blue  = WIN_SUM_W'(left_sum.blue) + WIN_SUM_W'(cell_sum[1].blue)
                         + WIN_SUM_W'(right_sum.blue);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= s2_valid_reg && s2_pos_reg.primed;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
        begin
            s3_sum_reg       <= win_sum;
            s3_row_end_reg   <= s2_pos_reg.col_last;
            s3_frame_end_reg <= s2_pos_reg.col_last && s2_pos_reg.row_last;
        end
    end

    assign push_data = '{px: '{red:   div9(s3_sum_reg.red),
                               green: div9(s3_sum_reg.green),
                               blue:  div9(s3_sum_reg.blue)},
                         row_end:   s3_row_end_reg,
                         frame_end: s3_frame_end_reg};

    bbr_out_fifo #(
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s3_valid_reg),
        .push_data (push_data),
        .pop       (pop),
        .valid     (fifo_valid),
        .head      (head)
    );

    assign blurred.valid     = fifo_valid;
    assign blurred.out_red   = head.px.red;
    assign blurred.out_green = head.px.green;
    assign blurred.out_blue  = head.px.blue;
    assign blurred.row_end   = head.row_end;
    assign blurred.frame_end = head.frame_end;

endmodule

FILE: rtl/core/bbr_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// A read at the address being written returns the old contents. No dependencies.
module bbr_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/core/bbr_cell.sv
// One column of the 3x3 window: holds three pixels, takes its neighbour's column on
// each shift and gives its row-masked channel sums. Depends on bbr_pkg.
module bbr_cell import bbr_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      shift,
    input  logic      clear,
    input  column_t   col_in,
    input  row_mask_t mask,
    output column_t   col_out,
    output col_sum_t  sum
);

    column_t col_reg;
    pixel_t  top_px;
    pixel_t  bot_px;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
        end
        else if (shift)
        begin
            col_reg <= col_in;
        end
        else if (clear)
        begin
            col_reg <= '0;
        end
    end

    // Drop rows that fall outside the frame
    assign top_px = mask.top_off ? '0 : col_reg.top;
    assign bot_px = mask.bot_off ? '0 : col_reg.bot;

    assign sum.red   = COL_SUM_W'(top_px.red) + COL_SUM_W'(col_reg.mid.red)
                     + COL_SUM_W'(bot_px.red);
    assign sum.green = COL_SUM_W'(top_px.green) + COL_SUM_W'(col_reg.mid.green)
                     + COL_SUM_W'(bot_px.green);
    assign sum.blue  = COL_SUM_W'(top_px.blue) + COL_SUM_W'(col_reg.mid.blue)
                     + COL_SUM_W'(bot_px.blue);

    assign col_out = col_reg;

endmodule

FILE: rtl/core/bbr_out_fifo.sv
// Small register FIFO that holds finished blurred pixels until the sink takes them.
// Depends on bbr_pkg for the result type.
module bbr_out_fifo import bbr_pkg::*; #(
    parameter int DEPTH = OUT_DEPTH_DEFAULT
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    input  logic    pop,
    output logic    valid,
    output result_t head
);

    localparam int PW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);

    result_t         slot_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [NW-1:0]   count_reg;
    logic [NW-1:0]   count_next;

    always_comb
    begin
        count_next = count_reg + NW'(push) - NW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign valid = (count_reg != '0);
    assign head  = slot_reg[rd_ptr_reg];

endmodule

FILE: rtl/core/bbr_checker.sv
// Port-level checks of the box blur, attached to the top level by the bind below.
// Depends on bbr_pkg and box_blur_3x3_rgb.
module bbr_checker import bbr_pkg::*; (
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input logic [PIX_W-1:0] out_red,
    input logic [PIX_W-1:0] out_green,
    input logic [PIX_W-1:0] out_blue,
    input logic             row_end,
    input logic             frame_end
);

    // No result is offered while reset is held
    a_reset_empty: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("output valid during reset");

    // A rising output valid traces back to the request that completed the result
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 4))
        else $error("output appeared without a request four cycles before");

    // The last pixel of a frame is also the last of its row
    a_frame_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_end |-> row_end)
        else $error("frame end without row end");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            out_valid && $stable({out_red, out_green, out_blue, row_end, frame_end}))
        else $error("stalled result changed or dropped");

endmodule

bind box_blur_3x3_rgb bbr_checker u_bbr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pixels.valid),
    .in_ready  (pixels.ready),
    .out_valid (blurred.valid),
    .out_ready (blurred.ready),
    .out_red   (blurred.out_red),
    .out_green (blurred.out_green),
    .out_blue  (blurred.out_blue),
    .row_end   (blurred.row_end),
    .frame_end (blurred.frame_end)
);

FILE: test/tb_box_blur_3x3_rgb.sv
// Testbench for box_blur_3x3_rgb: streams raster frames of random RGB pixels under
// several idling patterns and frame sizes, and checks each blurred pixel against a
// built-in model of the blur. Depends on bbr_pkg, bbr_if and the block itself.
module tb_box_blur_3x3_rgb import bbr_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_DEPTH     = MAX_WIDTH_DEFAULT;
    localparam int BLUR_TAPS      = 9;
    localparam int DRAIN_PAD      = 16;
    localparam int CYCLE_LIMIT    = 500000;
    localparam int PHASE_REQUESTS = 240;
    localparam int TALL_REQUESTS  = 48;

    typedef struct packed {
        pixel_t px;
        logic   drain;
    } src_req_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    bbr_in_if  pixels_bus ();
    bbr_out_if blurred_bus ();

    src_req_t pending_requests [$];
    result_t  blur_expected [$];

    // Model state: two line stores, the 3x3 window and the raster positions
    pixel_t                older_row [LINE_DEPTH];
    pixel_t                newer_row [LINE_DEPTH];
    pixel_t                win_cell [BLUR_TAPS];
    int unsigned           in_col = 0;
    int unsigned           in_row = 0;
    int unsigned           out_col = 0;
    int unsigned           out_row = 0;
    logic [CFG_DATA_W-1:0] frame_w_reg = CFG_DATA_W'(FRAME_DIM_RESET);
    logic [CFG_DATA_W-1:0] frame_h_reg = CFG_DATA_W'(FRAME_DIM_RESET);

    int unsigned sender_idle_pct = 0;
    int unsigned recv_stall_pct  = 0;
    int unsigned fail_count      = 0;
    int unsigned requests_taken  = 0;
    int unsigned pixels_checked  = 0;
    int unsigned frames_done     = 0;
    int unsigned cycle_count     = 0;

    box_blur_3x3_rgb #(
        .MAX_WIDTH (LINE_DEPTH)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixels    (pixels_bus),
        .blurred   (blurred_bus)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int unsigned sat_width(input logic [CFG_DATA_W-1:0] value);
        if (value == '0)
            return 1;
        else if (value > LINE_DEPTH)
            return LINE_DEPTH;
        return value;
    endfunction

    function automatic int unsigned sat_height(input logic [CFG_DATA_W-1:0] value);
        if (value == '0)
            return 1;
        else if (value > HEIGHT_LIMIT)
            return HEIGHT_LIMIT;
        return value;
    endfunction

    function automatic void restart_blur();
        in_col  = 0;
        in_row  = 0;
        out_col = 0;
        out_row = 0;
        foreach (win_cell[k])
            win_cell[k] = '0;
    endfunction

    // Advance the model by one accepted request; queue the blurred pixel it completes
    task automatic blur_accept(input pixel_t src, input logic drain_bit);
        int unsigned w, h, c, r, idx, sr, sg, sb, i, j;
        pixel_t      pix, v;
        logic        primed;
        result_t     res;
        w   = sat_width(frame_w_reg);
        h   = sat_height(frame_h_reg);
        c   = in_col;
        r   = in_row;
        idx = c % LINE_DEPTH;
        pix = '0;
        if (!drain_bit && r < h)
            pix = src;
        for (i = 0; i < 6; i++)
            win_cell[i] = win_cell[i + 3];
        win_cell[6]    = older_row[idx];
        win_cell[7]    = newer_row[idx];
        win_cell[8]    = pix;
        older_row[idx] = newer_row[idx];
        newer_row[idx] = pix;
        primed = (r >= 2) || (r == 1 && c >= 1);
        if (c + 1 >= w)
        begin
            in_col = 0;
            in_row = r + 1;
        end
        else
            in_col = c + 1;
        if (primed)
        begin
            sr = 0;
            sg = 0;
            sb = 0;
            // window cell [col*3 + row]; drop taps that fall outside the frame
            for (j = 0; j < 3; j++)
                for (i = 0; i < 3; i++)
                    if (!(j == 0 && out_col == 0) && !(j == 2 && out_col + 1 >= w) &&
                        !(i == 0 && out_row == 0) && !(i == 2 && out_row + 1 >= h))
                    begin
                        v  = win_cell[j * 3 + i];
                        sr += v.red;
                        sg += v.green;
                        sb += v.blue;
                    end
            res.px.red    = PIX_W'(sr / BLUR_TAPS);
            res.px.green  = PIX_W'(sg / BLUR_TAPS);
            res.px.blue   = PIX_W'(sb / BLUR_TAPS);
            res.row_end   = (out_col + 1 >= w);
            res.frame_end = res.row_end && (out_row + 1 >= h);
            if (res.frame_end)
                restart_blur();
            else if (res.row_end)
            begin
                out_col = 0;
                out_row = out_row + 1;
            end
            else
                out_col = out_col + 1;
            blur_expected.push_back(res);
        end
    endtask

    function automatic void check_field(input string field, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            fail_count++;
        end
    endfunction

    function automatic logic [PIX_W-1:0] rand_chan();
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            default: return PIX_W'($urandom_range(255));
        endcase
    endfunction

    function automatic void queue_pixel(input logic [PIX_W-1:0] red, input logic [PIX_W-1:0] green,
                                        input logic [PIX_W-1:0] blue, input logic drain_bit);
        src_req_t req;
        req.px.red   = red;
        req.px.green = green;
        req.px.blue  = blue;
        req.drain    = drain_bit;
        pending_requests.push_back(req);
    endfunction

    // Source side: hold a request until taken, feed the model on every acceptance
    always @(posedge clk or negedge rst_n)
    begin : source_drive
        src_req_t next_req;
        if (!rst_n)
        begin
            pixels_bus.valid    <= 1'b0;
            pixels_bus.in_red   <= '0;
            pixels_bus.in_green <= '0;
            pixels_bus.in_blue  <= '0;
            pixels_bus.drain    <= 1'b0;
        end
        else
        begin
            if (pixels_bus.valid && pixels_bus.ready)
            begin
                blur_accept({pixels_bus.in_red, pixels_bus.in_green, pixels_bus.in_blue},
                            pixels_bus.drain);
                requests_taken++;
            end
            if (!pixels_bus.valid || pixels_bus.ready)
            begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    next_req = pending_requests.pop_front();
                    pixels_bus.valid    <= 1'b1;
                    pixels_bus.in_red   <= next_req.px.red;
                    pixels_bus.in_green <= next_req.px.green;
                    pixels_bus.in_blue  <= next_req.px.blue;
                    pixels_bus.drain    <= next_req.drain;
                end
                else
                    pixels_bus.valid <= 1'b0;
            end
        end
    end

    // Sink side: random stalls, compare every blurred pixel with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin : sink_check
        result_t want;
        if (!rst_n)
            blurred_bus.ready <= 1'b0;
        else
        begin
            if (blurred_bus.valid && blurred_bus.ready)
            begin
                if (blur_expected.size() == 0)
                begin
                    $error("blurred pixel with no prediction pending");
                    fail_count++;
                end
                else
                begin
                    want = blur_expected.pop_front();
                    check_field("out_red", want.px.red, blurred_bus.out_red);
                    check_field("out_green", want.px.green, blurred_bus.out_green);
                    check_field("out_blue", want.px.blue, blurred_bus.out_blue);
                    check_field("row_end", want.row_end, blurred_bus.row_end);
                    check_field("frame_end", want.frame_end, blurred_bus.frame_end);
                    pixels_checked++;
                    if (want.frame_end)
                        frames_done++;
                end
            end
            blurred_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Wait until every request is taken and every blurred pixel is out, then let the pipe empty
    task automatic settle();
        while (pending_requests.size() != 0 || pixels_bus.valid)
            @(negedge clk);
        while (blur_expected.size() != 0)
            @(negedge clk);
        repeat (DRAIN_PAD) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t which, input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= which;
        cfg_data  <= value;
        if (which == REG_FRAME_WIDTH)
            frame_w_reg = value;
        else
            frame_h_reg = value;
        restart_blur();
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Queue n requests of a w x h frame: pixels first, then the drain tail
    task automatic send_frame(input int unsigned w, input int unsigned h, input int unsigned n,
                              input int unsigned idle_in, input int unsigned stall_out);
        int unsigned k;
        @(negedge clk);
        sender_idle_pct = idle_in;
        recv_stall_pct  = stall_out;
        for (k = 0; k < n; k++)
        begin
            // tail items with drain low must still act as bubbles
            if (k < w * h)
                queue_pixel(rand_chan(), rand_chan(), rand_chan(), $urandom_range(31) == 0);
            else
                queue_pixel(rand_chan(), rand_chan(), rand_chan(), $urandom_range(3) != 0);
        end
    endtask

    task automatic random_phase(input int unsigned idle_in, input int unsigned stall_out);
        int unsigned           sent, w, h, n;
        logic [CFG_DATA_W-1:0] w_raw, h_raw;
        bit                    reconfig;
        sent     = 0;
        reconfig = 1'b1;
        while (sent < PHASE_REQUESTS)
        begin
            if (reconfig || $urandom_range(3) != 0)
            begin
                settle();
                case ($urandom_range(9))
                    0:       w_raw = '0;
                    1:       w_raw = CFG_DATA_W'(1);
                    2:       w_raw = CFG_DATA_W'(2);
                    default: w_raw = CFG_DATA_W'($urandom_range(3, 12));
                endcase
                case ($urandom_range(9))
                    0:       h_raw = '0;
                    1:       h_raw = CFG_DATA_W'(1);
                    default: h_raw = CFG_DATA_W'($urandom_range(2, 8));
                endcase
                if (sat_width(frame_w_reg) <= 16 && $urandom_range(3) == 0)
                    write_reg(REG_FRAME_HEIGHT, h_raw);
                else
                begin
                    write_reg(REG_FRAME_WIDTH, w_raw);
                    write_reg(REG_FRAME_HEIGHT, h_raw);
                end
            end
            w = sat_width(frame_w_reg);
            h = sat_height(frame_h_reg);
            n = w * h + w + 1;
            reconfig = 1'b0;
            // cut a frame short now and then; the next register write must restart it
            if ($urandom_range(5) == 0)
            begin
                n = $urandom_range(1, n - 1);
                reconfig = 1'b1;
            end
            if ($urandom_range(4) == 0)
                send_frame(w, h, n, 0, 0);
            else
                send_frame(w, h, n, idle_in, stall_out);
            sent += n;
        end
        settle();
    endtask

    initial
    begin
        rst_n               = 1'b0;
        cfg_wr_en           = 1'b0;
        cfg_index           = REG_FRAME_WIDTH;
        cfg_data            = '0;
        foreach (older_row[k])
        begin
            older_row[k] = '0;
            newer_row[k] = '0;
        end
        restart_blur();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Reset frame size: the first two pixels of the output frame
        send_frame(FRAME_DIM_RESET, FRAME_DIM_RESET, FRAME_DIM_RESET + 3, 0, 0);
        settle();

        // Zero size saturates to a single pixel; a full-scale pixel past the frame is a bubble
        write_reg(REG_FRAME_WIDTH, '0);
        write_reg(REG_FRAME_HEIGHT, '0);
        @(negedge clk);
        queue_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
        queue_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
        queue_pixel(8'h00, 8'h00, 8'h00, 1'b1);
        settle();

        // 3x2 with a drain inside the frame standing for a black pixel
        write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(3));
        write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(2));
        @(negedge clk);
        queue_pixel(8'hFF, 8'h00, 8'hFF, 1'b0);
        queue_pixel(8'h00, 8'hFF, 8'h00, 1'b0);
        queue_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
        queue_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
        queue_pixel(8'h00, 8'h00, 8'h00, 1'b0);
        queue_pixel(8'h80, 8'h40, 8'h20, 1'b0);
        queue_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
        queue_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
        queue_pixel(8'h00, 8'h00, 8'h00, 1'b1);
        queue_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
        settle();

        // Abandon a 2x2 frame part way, restart it with a height write alone
        write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(2));
        write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(2));
        @(negedge clk);
        queue_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
        queue_pixel(8'hFF, 8'h00, 8'h00, 1'b0);
        queue_pixel(8'h00, 8'hFF, 8'h00, 1'b0);
        queue_pixel(8'h00, 8'h00, 8'hFF, 1'b0);
        settle();
        write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(3));
        send_frame(2, 3, 9, 0, 0);
        settle();

        random_phase(0, 0);
        random_phase(73, 0);
        random_phase(0, 73);

        // Single column against an oversized height: the first rows of a tall frame
        write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(1));
        write_reg(REG_FRAME_HEIGHT, '1);
        send_frame(1, HEIGHT_LIMIT, TALL_REQUESTS, 30, 30);
        random_phase(30, 30);

        settle();
        $display("%0d source requests taken, %0d blurred pixels checked, %0d frames completed",
                 requests_taken, pixels_checked, frames_done);
        $display("frames from 1x1 up to 12x8, the reset size and a tall single column, %s",
                 "under four idling patterns");
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/bbr_pkg.sv
rtl/core/bbr_if.sv
rtl/core/bbr_ram.sv
rtl/core/bbr_cell.sv
rtl/core/bbr_out_fifo.sv
rtl/core/box_blur_3x3_rgb.sv
rtl/core/bbr_checker.sv
test/tb_box_blur_3x3_rgb.sv
